/* src/ute_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ute_pkg
// Shared types, constants and byte-encoding helpers for the UTF-16 to UTF-8
// encoder.
// ----------------------------------------------------------------------------
package ute_pkg;

   localparam int UNIT_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int CP_W      = 21;
   localparam int SURR_W    = 10;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // top six bits of a surrogate code unit
   localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;   // 0xD800..0xDBFF
   localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;   // 0xDC00..0xDFFF

   // index of the last byte of a sequence
   typedef enum logic [1:0] {
      LEN_1 = 2'd0,
      LEN_2 = 2'd1,
      LEN_3 = 2'd2,
      LEN_4 = 2'd3
   } len_type;

   // one queued job: optional flush of a held surrogate, then optional code point
   typedef struct packed {
      logic            first_valid;
      logic [CP_W-1:0] first_cp;
      logic            second_valid;
      logic [CP_W-1:0] second_cp;
   } job_type;

   function automatic len_type enc_len(input logic [CP_W-1:0] cp);
      len_type len;
      if (cp < CP_W'(32'h80))         len = LEN_1;
      else if (cp < CP_W'(32'h800))   len = LEN_2;
      else if (cp < CP_W'(32'h10000)) len = LEN_3;
      else                            len = LEN_4;
      return len;
   endfunction

   function automatic logic [BYTE_W-1:0] enc_byte(input logic [CP_W-1:0] cp,
                                                  input len_type len,
                                                  input logic [1:0] idx);
      logic [BYTE_W-1:0] b;
      b = {2'b10, cp[5:0]};
      unique case (len)
         LEN_1: b = cp[7:0];
         LEN_2: begin
            if (idx == 2'd0) b = {3'b110, cp[10:6]};
            else             b = {2'b10, cp[5:0]};
         end
         LEN_3: begin
            unique case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         LEN_4: begin
            unique case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: b = cp[7:0];
      endcase
      return b;
   endfunction

endpackage

/* src/ute_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ute channel interfaces
// Valid/ready channels for code units in and UTF-8 bytes out.
// ----------------------------------------------------------------------------
interface ute_req_if;
   logic                         valid;
   logic                         ready;
   logic [ute_pkg::UNIT_W-1:0]   code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink   (input valid, input code_unit, output ready);
endinterface

interface ute_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ute_pkg::BYTE_W-1:0]   out_byte;
   logic                         last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* src/ute_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ute_front
// Accepts code units, tracks the held high surrogate and builds jobs.
// ----------------------------------------------------------------------------
module ute_front (
   input  logic              clock,
   input  logic              reset,
   ute_req_if.sink           req_if,
   input  logic              q_full,
   output logic              q_push,
   output ute_pkg::job_type  q_job
);

   logic                            held_valid_ff, held_valid_in;
   logic [ute_pkg::SURR_W-1:0]      held_bits_ff,  held_bits_in;
   logic                            accept;
   logic                            is_high, is_low, is_zero;
   logic [ute_pkg::UNIT_W-1:0]      u;
   ute_pkg::job_type                job;

   assign u       = req_if.code_unit;
   assign is_high = (u[15:10] == ute_pkg::HIGH_SURR_TAG);
   assign is_low  = (u[15:10] == ute_pkg::LOW_SURR_TAG);
   assign is_zero = (u == '0);

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      job              = '0;
      held_valid_in    = held_valid_ff;
      held_bits_in     = held_bits_ff;
      if (held_valid_ff && is_low) begin
         // surrogate pair: 0x10000 + (high << 10) + low offset
         job.second_valid = 1'b1;
         job.second_cp    = {11'(held_bits_ff) + 11'd64, u[9:0]};
      end else begin
         job.first_valid  = held_valid_ff;
         job.first_cp     = {5'b0, ute_pkg::HIGH_SURR_TAG, held_bits_ff};
         job.second_valid = !is_zero && !is_high;
         job.second_cp    = {5'b0, u};
      end
      if (accept) begin
         held_valid_in = is_high && !(held_valid_ff && is_low);
         held_bits_in  = is_high ? u[9:0] : '0;
      end
   end

   assign q_push = accept && (job.first_valid || job.second_valid);
   assign q_job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_bits_ff  <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_bits_ff  <= held_bits_in;
      end
   end

endmodule

/* src/ute_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ute_queue
// Short job queue decoupling the front and back parts.
// ----------------------------------------------------------------------------
module ute_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ute_pkg::job_type  push_job,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output ute_pkg::job_type  head
);

   ute_pkg::job_type                 mem_ff [ute_pkg::QUEUE_DEPTH];
   logic [ute_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ute_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ute_pkg::QCNT_W-1:0]       count_ff,  count_in;

   function automatic logic [ute_pkg::QPTR_W-1:0] ptr_next(
      input logic [ute_pkg::QPTR_W-1:0] p);
      logic [ute_pkg::QPTR_W-1:0] n;
      if (p == ute_pkg::QPTR_W'(ute_pkg::QUEUE_DEPTH - 1)) n = '0;
      else                                                   n = p + 1'b1;
      return n;
   endfunction

   assign full  = (count_ff == ute_pkg::QCNT_W'(ute_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ute_pkg::QCNT_W'(ute_pkg::QUEUE_DEPTH))
      else $error("queue occupancy beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

/* src/ute_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ute_back
// Walks each job byte by byte into the registered output stage.
// ----------------------------------------------------------------------------
module ute_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  ute_pkg::job_type  q_head,
   output logic              q_pop,
   ute_rsp_if.source         rsp_if
);

   logic                          seg_ff, seg_in;
   logic [1:0]                    idx_ff, idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ute_pkg::BYTE_W-1:0]    byte_ff, byte_in;
   logic                          last_ff, last_in;

   logic                          eff_seg;
   logic [ute_pkg::CP_W-1:0]      cur_cp;
   ute_pkg::len_type              cur_len;
   logic                          last_in_seg, more, emit, run_last;

   assign eff_seg     = seg_ff || !q_head.first_valid;
   assign cur_cp      = eff_seg ? q_head.second_cp : q_head.first_cp;
   assign cur_len     = ute_pkg::enc_len(cur_cp);
   assign last_in_seg = (idx_ff == 2'(cur_len));
   assign more        = !eff_seg && q_head.second_valid;
   assign run_last    = last_in_seg && !more;
   assign emit        = !q_empty && (!rsp_valid_ff || rsp_if.ready);
   assign q_pop       = emit && run_last;

   always_comb begin
      seg_in       = seg_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         byte_in      = ute_pkg::enc_byte(cur_cp, cur_len, idx_ff);
         last_in      = run_last;
         if (last_in_seg) begin
            idx_in = '0;
            seg_in = more;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_byte    = byte_ff;
   assign rsp_if.last_of_run = last_ff;

endmodule

/* src/utf16_to_utf8_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// UTF-16 code unit stream in, UTF-8 byte stream out.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one 16-bit code unit per transaction; rsp_if carries one
//   UTF-8 byte per transaction, with last_of_run set on the final byte caused
//   by a code unit. A zero unit ends the string: it only flushes a held high
//   surrogate. A high surrogate produces no bytes until the next unit arrives.
//   The first byte of a unit passes through the job queue and then the
//   output register of the back part before it is valid on rsp_if.
//   Bytes leave at one byte per cycle while jobs wait and the receiver is
//   ready, so a unit costs output time for each byte it causes (0 to 6,
//   typically 1 to 3); the single-byte output register of the back part sets
//   this. Units are taken back to back while the two-entry job queue has room.
//   Reset (synchronous, active high) empties the queue, drops any held
//   surrogate and the output register. When the receiver stalls, the output
//   byte holds, the back part waits, and the front keeps taking units until
//   the queue fills.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder (
   input  logic     clock,
   input  logic     reset,
   ute_req_if.sink  req_if,
   ute_rsp_if.source rsp_if
);

   // front -> queue
   logic             q_push;
   ute_pkg::job_type q_push_job;
   // queue -> back
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   ute_pkg::job_type q_head;

   // Front: surrogate pairing and job building, one unit per cycle while the queue has room
   ute_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (q_push_job)
   );

   // Job queue so the two halves stall independently
   ute_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   // Back: byte sequencer with registered output
   ute_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule

/* tb/sv/tb_utf16_to_utf8_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_encoder
// Self-checking bench for the UTF-16 to UTF-8 encoder. A queue of code units
// is fed through the request channel. A local encoder model predicts the
// UTF-8 bytes for every unit as it is accepted. A monitor compares each byte
// transaction with the oldest prediction. Both sides idle at random, and the
// receiver holds off for long stretches so that the job queue fills.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_encoder;

   // surrogate ranges and encoding boundaries
   localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
   localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
   localparam logic [15:0] END_OF_STRING = 16'h0000;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;
   localparam logic [20:0] ONE_BYTE_LIM  = 21'h80;
   localparam logic [20:0] TWO_BYTE_LIM  = 21'h800;
   localparam logic [20:0] THREE_BYTE_LIM = 21'h10000;

   localparam int RANDOM_UNITS   = 340;
   localparam int LONG_HOLD      = 90;   // receiver hold-off, in cycles
   localparam int TRAIL_CYCLES   = 20;
   localparam int MAX_REPORTED   = 10;

   typedef struct {
      logic [ute_pkg::UNIT_W-1:0] unit;
      bit                         drain_first;   // wait for all bytes before offering
   } pending_unit_type;

   typedef struct {
      logic [ute_pkg::BYTE_W-1:0] value;
      logic                       last;
   } utf8_byte_type;

   logic clock;
   logic reset;

   ute_req_if req_ch ();
   ute_rsp_if rsp_ch ();

   utf16_to_utf8_encoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // stimulus waiting to be sent, and bytes still owed by the block
   pending_unit_type pending_units[$];
   utf8_byte_type    expected_bytes[$];

   // encoder model state
   logic          model_held = 1'b0;
   logic [9:0]    model_high_bits = '0;

   int            units_total;
   int            units_accepted = 0;
   int            bytes_seen = 0;
   int            error_count = 0;

   int            send_gap;
   int            send_quiet;
   int            recv_gap;
   int            recv_quiet;
   pending_unit_type next_item;
   utf8_byte_type    oldest;

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // -------------------------------------------------------------------------
   // Encoder model
   // -------------------------------------------------------------------------

   // append the UTF-8 sequence of one code point, last flag cleared
   function automatic int push_utf8_sequence(input logic [20:0] cp);
      utf8_byte_type b;
      int            count;
      count   = 0;
      b.last  = 1'b0;
      if (cp < ONE_BYTE_LIM) begin
         b.value = cp[7:0];
         expected_bytes.insert(expected_bytes.size(), b);
         count = 1;
      end else if (cp < TWO_BYTE_LIM) begin
         b.value = {3'b110, cp[10:6]};
         expected_bytes.insert(expected_bytes.size(), b);
         b.value = {2'b10, cp[5:0]};
         expected_bytes.insert(expected_bytes.size(), b);
         count = 2;
      end else if (cp < THREE_BYTE_LIM) begin
         b.value = {4'b1110, cp[15:12]};
         expected_bytes.insert(expected_bytes.size(), b);
         b.value = {2'b10, cp[11:6]};
         expected_bytes.insert(expected_bytes.size(), b);
         b.value = {2'b10, cp[5:0]};
         expected_bytes.insert(expected_bytes.size(), b);
         count = 3;
      end else begin
         b.value = {5'b11110, cp[20:18]};
         expected_bytes.insert(expected_bytes.size(), b);
         b.value = {2'b10, cp[17:12]};
         expected_bytes.insert(expected_bytes.size(), b);
         b.value = {2'b10, cp[11:6]};
         expected_bytes.insert(expected_bytes.size(), b);
         b.value = {2'b10, cp[5:0]};
         expected_bytes.insert(expected_bytes.size(), b);
         count = 4;
      end
      return count;
   endfunction

   // work out the bytes one accepted code unit causes
   function automatic void predict_utf8(input logic [ute_pkg::UNIT_W-1:0] unit);
      logic is_high;
      logic is_low;
      int   count;
      is_high = (unit >= HIGH_SURR_MIN) && (unit <= HIGH_SURR_MAX);
      is_low  = (unit >= LOW_SURR_MIN) && (unit <= LOW_SURR_MAX);
      count   = 0;

      if (model_held && is_low) begin
         // surrogate pair: one supplementary code point
         count = push_utf8_sequence(SUPP_BASE + {1'b0, model_high_bits, unit[9:0]});
         model_held      = 1'b0;
         model_high_bits = '0;
      end else begin
         if (model_held) begin
            // unpaired high surrogate goes out on its own
            count = push_utf8_sequence({5'b0, HIGH_SURR_MIN[15:10], model_high_bits});
            model_held      = 1'b0;
            model_high_bits = '0;
         end
         if (unit == END_OF_STRING) begin
            model_high_bits = '0;
         end else if (is_high) begin
            model_held      = 1'b1;
            model_high_bits = unit[9:0];
         end else begin
            count += push_utf8_sequence({5'b0, unit});
         end
      end

      if (count > 0)
         expected_bytes[expected_bytes.size() - 1].last = 1'b1;
   endfunction

   // -------------------------------------------------------------------------
   // Helpers
   // -------------------------------------------------------------------------

   // idle cycles before the next transaction; now and then a stretch with none
   function automatic int draw_gap(inout int quiet_left);
      int gap;
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 7);
         if ($urandom_range(0, 15) == 0)
            quiet_left = $urandom_range(10, 30);
      end
      return gap;
   endfunction

   function automatic void queue_unit(input logic [ute_pkg::UNIT_W-1:0] unit,
                                      input bit drain);
      pending_unit_type p;
      p.unit        = unit;
      p.drain_first = drain;
      pending_units.insert(pending_units.size(), p);
   endfunction

   task automatic report_mismatch(input string what, input utf8_byte_type exp_b);
      error_count++;
      if (error_count <= MAX_REPORTED)
         $display("%s at byte %0d: expected %02h last %0b, got %02h last %0b",
                  what, bytes_seen, exp_b.value, exp_b.last,
                  rsp_ch.out_byte, rsp_ch.last_of_run);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------

   // directed corners, then random strings of mostly well-formed UTF-16
   task automatic build_stimulus();
      int          kind;
      int          n;
      logic [15:0] u;

      // byte-length boundaries; 0xFFFF and zero toggle every input bit
      queue_unit(16'h0041, 1'b0);
      queue_unit(END_OF_STRING, 1'b0);        // end of string, nothing held
      queue_unit(16'h007F, 1'b0);
      queue_unit(16'h0080, 1'b0);
      queue_unit(16'h07FF, 1'b0);
      queue_unit(16'h0800, 1'b0);
      queue_unit(16'hD7FF, 1'b0);
      queue_unit(16'hE000, 1'b0);
      queue_unit(16'hFFFF, 1'b0);
      // surrogate pairs at both ends of the supplementary range
      queue_unit(HIGH_SURR_MIN, 1'b0);
      queue_unit(LOW_SURR_MIN, 1'b0);
      queue_unit(HIGH_SURR_MAX, 1'b0);
      queue_unit(LOW_SURR_MAX, 1'b0);
      // lone low surrogates
      queue_unit(LOW_SURR_MIN, 1'b0);
      queue_unit(LOW_SURR_MAX, 1'b0);
      // high surrogate followed by an ordinary unit
      queue_unit(HIGH_SURR_MIN, 1'b0);
      queue_unit(16'h0041, 1'b0);
      // high, high, low: first flushed, second paired
      queue_unit(HIGH_SURR_MAX, 1'b0);
      queue_unit(HIGH_SURR_MIN, 1'b0);
      queue_unit(16'hDC01, 1'b0);
      // high surrogate flushed by end of string
      queue_unit(16'hDA12, 1'b0);
      queue_unit(END_OF_STRING, 1'b0);

      n = 0;
      while (n < RANDOM_UNITS) begin
         kind = $urandom_range(0, 19);
         // sender waits for the block to empty at up to two points
         if (n == 10 || n == 200)
            kind = 0;
         case (kind)
            0, 1, 2, 3, 4, 5:
               queue_unit(16'($urandom_range(1, 16'h7F)), n == 10 || n == 200);
            6, 7, 8:
               queue_unit(16'($urandom_range(16'h80, 16'h7FF)), 1'b0);
            9, 10, 11: begin
               if ($urandom_range(0, 1) == 0)
                  queue_unit(16'($urandom_range(16'h800, 16'hD7FF)), 1'b0);
               else
                  queue_unit(16'($urandom_range(16'hE000, 16'hFFFF)), 1'b0);
            end
            12, 13, 14, 15: begin
               queue_unit(HIGH_SURR_MIN | 16'($urandom_range(0, 16'h3FF)), 1'b0);
               queue_unit(LOW_SURR_MIN | 16'($urandom_range(0, 16'h3FF)), 1'b0);
               n++;
            end
            16:
               queue_unit(HIGH_SURR_MIN | 16'($urandom_range(0, 16'h3FF)), 1'b0);
            17:
               queue_unit(LOW_SURR_MIN | 16'($urandom_range(0, 16'h3FF)), 1'b0);
            18:
               queue_unit(END_OF_STRING, 1'b0);
            default: begin
               u = 16'($urandom());
               queue_unit(u, 1'b0);
            end
         endcase
         n++;
      end

      // close the string so nothing stays held
      queue_unit(END_OF_STRING, 1'b0);
   endtask

   // -------------------------------------------------------------------------
   // Driver: offers code units from the pending queue, predicts on acceptance
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.code_unit <= '0;
         send_gap          = 0;
         send_quiet        = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_utf8(req_ch.code_unit);
            units_accepted++;
            send_gap = draw_gap(send_quiet);
         end

         // a unit still on offer and not taken stays put
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               req_ch.valid <= 1'b0;
               send_gap--;
            end else if (pending_units.size() != 0 &&
                         !(pending_units[0].drain_first && expected_bytes.size() != 0)) begin
               next_item         = pending_units.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.code_unit <= next_item.unit;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: checks each byte transaction and paces the receiver's ready
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap      = 0;
         recv_quiet    = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_bytes.size() == 0) begin
               oldest.value = '0;
               oldest.last  = 1'b0;
               report_mismatch("unexpected byte", oldest);
            end else begin
               oldest = expected_bytes.pop_front();
               if (rsp_ch.out_byte !== oldest.value || rsp_ch.last_of_run !== oldest.last)
                  report_mismatch("mismatch", oldest);
            end
            bytes_seen++;
            recv_gap = draw_gap(recv_quiet);
            // long hold-offs let the job queue fill and push back on the input
            if (bytes_seen == 120 || bytes_seen == 450)
               recv_gap = LONG_HOLD;
         end

         if (recv_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            recv_gap--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sequencing
   // -------------------------------------------------------------------------
   initial begin
      reset            = 1'b1;

      build_stimulus();
      units_total = pending_units.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // every unit taken, every byte back, then TRAIL_CYCLES quiet cycles for strays
      while (units_accepted != units_total) @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (TRAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("** utf16_to_utf8_encoder: PASSED **");
      end else begin
         $display("** utf16_to_utf8_encoder: FAILED **");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("** utf16_to_utf8_encoder: FAILED **");
      $finish;
   end

endmodule

/* filelist.f */
src/ute_pkg.sv
src/ute_ifs.sv
src/ute_front.sv
src/ute_queue.sv
src/ute_back.sv
src/utf16_to_utf8_encoder.sv
tb/sv/tb_utf16_to_utf8_encoder.sv
